// ----- hw/rtl/esra_pkg.sv -----
// Shared types, register-file map and the row-assembly microprogram.
package esra_pkg;

    typedef logic signed [63:0] q_t;

    // Grid point, velocity in the lowest bits.
    typedef struct packed {
        q_t t;
        q_t y;
        q_t lt;
        q_t mt;
        q_t mu;
        q_t u;
    } point_t;

    // Result of a multi-cycle arithmetic unit.
    typedef struct packed {
        logic done;
        logic sat;
        q_t   val;
    } unit_res_t;

    localparam q_t Q_ONE  = 64'sh0000_0001_0000_0000;
    localparam q_t Q_HALF = 64'sh0000_0000_8000_0000;
    localparam q_t Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q_t Q_MIN  = 64'sh8000_0000_0000_0000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CP_OVER_PR  = 2'd0;
    localparam logic [1:0] CFG_TURB_ENABLE = 2'd1;
    localparam logic [1:0] CFG_TURB_MULT   = 2'd2;

    // Register-file map: points 0..2, constants, temporaries.
    localparam logic [4:0] R_U0   = 5'd0;
    localparam logic [4:0] R_U1   = 5'd1;
    localparam logic [4:0] R_U2   = 5'd2;
    localparam logic [4:0] R_MU0  = 5'd3;
    localparam logic [4:0] R_MU1  = 5'd4;
    localparam logic [4:0] R_MU2  = 5'd5;
    localparam logic [4:0] R_MT0  = 5'd6;
    localparam logic [4:0] R_MT1  = 5'd7;
    localparam logic [4:0] R_MT2  = 5'd8;
    localparam logic [4:0] R_LT0  = 5'd9;
    localparam logic [4:0] R_LT1  = 5'd10;
    localparam logic [4:0] R_LT2  = 5'd11;
    localparam logic [4:0] R_Y0   = 5'd12;
    localparam logic [4:0] R_Y1   = 5'd13;
    localparam logic [4:0] R_Y2   = 5'd14;
    localparam logic [4:0] R_T0   = 5'd15;
    localparam logic [4:0] R_T1   = 5'd16;
    localparam logic [4:0] R_T2   = 5'd17;
    localparam logic [4:0] R_C    = 5'd18;
    localparam logic [4:0] R_F    = 5'd19;
    localparam logic [4:0] R_HALF = 5'd20;
    localparam logic [4:0] R_X0   = 5'd21;
    localparam logic [4:0] R_X1   = 5'd22;
    localparam logic [4:0] R_DY2  = 5'd23;
    localparam logic [4:0] R_DYF  = 5'd24;
    localparam logic [4:0] R_DYB  = 5'd25;
    localparam logic [4:0] R_DFE  = 5'd26;
    localparam logic [4:0] R_DBE  = 5'd27;
    localparam logic [4:0] R_DFM  = 5'd28;
    localparam logic [4:0] R_DBM  = 5'd29;
    localparam logic [4:0] R_A    = 5'd30;
    localparam logic [4:0] R_B    = 5'd31;

    localparam int NUM_LOAD = 21;
    localparam int PROG_LEN = 61;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_NEG = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_RCP = 3'd4;

    localparam logic [2:0] O_NONE = 3'd0;
    localparam logic [2:0] O_RHS  = 3'd1;
    localparam logic [2:0] O_DIAG = 3'd2;
    localparam logic [2:0] O_SUB  = 3'd3;
    localparam logic [2:0] O_SUP  = 3'd4;

    localparam logic [1:0] C_ALL = 2'd0;
    localparam logic [1:0] C_SUB = 2'd1;
    localparam logic [1:0] C_SUP = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] a;
        logic [4:0] b;
        logic [4:0] d;
        logic [2:0] o;
        logic [1:0] cond;
    } uop_t;

    function automatic uop_t mk(input logic [2:0] op, input logic [4:0] a,
                                input logic [4:0] b, input logic [4:0] d,
                                input logic [2:0] o, input logic [1:0] cond);
        uop_t r;
        r.op   = op;
        r.a    = a;
        r.b    = b;
        r.d    = d;
        r.o    = o;
        r.cond = cond;
        return r;
    endfunction

    function automatic uop_t prog_rom(input logic [5:0] pc);
        uop_t r;
        unique case (pc)
            6'd0:  r = mk(OP_SUB, R_Y2,   R_Y0,  R_X0,  O_NONE, C_ALL);
            6'd1:  r = mk(OP_MUL, R_HALF, R_X0,  R_X0,  O_NONE, C_ALL);
            6'd2:  r = mk(OP_RCP, R_X0,   R_X0,  R_DY2, O_NONE, C_ALL);
            6'd3:  r = mk(OP_SUB, R_Y2,   R_Y1,  R_X0,  O_NONE, C_ALL);
            6'd4:  r = mk(OP_RCP, R_X0,   R_X0,  R_DYF, O_NONE, C_ALL);
            6'd5:  r = mk(OP_SUB, R_Y1,   R_Y0,  R_X0,  O_NONE, C_ALL);
            6'd6:  r = mk(OP_RCP, R_X0,   R_X0,  R_DYB, O_NONE, C_ALL);
            6'd7:  r = mk(OP_ADD, R_MU1,  R_MU2, R_X0,  O_NONE, C_ALL);
            6'd8:  r = mk(OP_MUL, R_C,    R_X0,  R_X0,  O_NONE, C_ALL);
            6'd9:  r = mk(OP_ADD, R_LT1,  R_LT2, R_X1,  O_NONE, C_ALL);
            6'd10: r = mk(OP_MUL, R_F,    R_X1,  R_X1,  O_NONE, C_ALL);
            6'd11: r = mk(OP_ADD, R_X0,   R_X1,  R_X0,  O_NONE, C_ALL);
            6'd12: r = mk(OP_MUL, R_HALF, R_X0,  R_DFE, O_NONE, C_ALL);
            6'd13: r = mk(OP_ADD, R_MU1,  R_MU0, R_X0,  O_NONE, C_ALL);
            6'd14: r = mk(OP_MUL, R_C,    R_X0,  R_X0,  O_NONE, C_ALL);
            6'd15: r = mk(OP_ADD, R_LT1,  R_LT0, R_X1,  O_NONE, C_ALL);
            6'd16: r = mk(OP_MUL, R_F,    R_X1,  R_X1,  O_NONE, C_ALL);
            6'd17: r = mk(OP_ADD, R_X0,   R_X1,  R_X0,  O_NONE, C_ALL);
            6'd18: r = mk(OP_MUL, R_HALF, R_X0,  R_DBE, O_NONE, C_ALL);
            6'd19: r = mk(OP_MUL, R_F,    R_MT2, R_X0,  O_NONE, C_ALL);
            6'd20: r = mk(OP_ADD, R_MU2,  R_X0,  R_X0,  O_NONE, C_ALL);
            6'd21: r = mk(OP_MUL, R_X0,   R_U2,  R_X0,  O_NONE, C_ALL);
            6'd22: r = mk(OP_MUL, R_F,    R_MT1, R_X1,  O_NONE, C_ALL);
            6'd23: r = mk(OP_ADD, R_MU1,  R_X1,  R_X1,  O_NONE, C_ALL);
            6'd24: r = mk(OP_MUL, R_X1,   R_U1,  R_X1,  O_NONE, C_ALL);
            6'd25: r = mk(OP_ADD, R_X0,   R_X1,  R_X0,  O_NONE, C_ALL);
            6'd26: r = mk(OP_MUL, R_HALF, R_X0,  R_DFM, O_NONE, C_ALL);
            6'd27: r = mk(OP_MUL, R_F,    R_MT0, R_X0,  O_NONE, C_ALL);
            6'd28: r = mk(OP_ADD, R_MU0,  R_X0,  R_X0,  O_NONE, C_ALL);
            6'd29: r = mk(OP_MUL, R_X0,   R_U0,  R_X0,  O_NONE, C_ALL);
            6'd30: r = mk(OP_MUL, R_F,    R_MT1, R_X1,  O_NONE, C_ALL);
            6'd31: r = mk(OP_ADD, R_MU1,  R_X1,  R_X1,  O_NONE, C_ALL);
            6'd32: r = mk(OP_MUL, R_X1,   R_U1,  R_X1,  O_NONE, C_ALL);
            6'd33: r = mk(OP_ADD, R_X0,   R_X1,  R_X0,  O_NONE, C_ALL);
            6'd34: r = mk(OP_MUL, R_HALF, R_X0,  R_DBM, O_NONE, C_ALL);
            6'd35: r = mk(OP_SUB, R_T2,   R_T1,  R_X0,  O_NONE, C_ALL);
            6'd36: r = mk(OP_MUL, R_DFE,  R_X0,  R_X0,  O_NONE, C_ALL);
            6'd37: r = mk(OP_MUL, R_X0,   R_DYF, R_X0,  O_NONE, C_ALL);
            6'd38: r = mk(OP_SUB, R_T1,   R_T0,  R_X1,  O_NONE, C_ALL);
            6'd39: r = mk(OP_MUL, R_DBE,  R_X1,  R_X1,  O_NONE, C_ALL);
            6'd40: r = mk(OP_MUL, R_X1,   R_DYB, R_X1,  O_NONE, C_ALL);
            6'd41: r = mk(OP_SUB, R_X0,   R_X1,  R_A,   O_NONE, C_ALL);
            6'd42: r = mk(OP_SUB, R_U2,   R_U1,  R_X0,  O_NONE, C_ALL);
            6'd43: r = mk(OP_MUL, R_DFM,  R_X0,  R_X0,  O_NONE, C_ALL);
            6'd44: r = mk(OP_MUL, R_X0,   R_DYF, R_X0,  O_NONE, C_ALL);
            6'd45: r = mk(OP_SUB, R_U1,   R_U0,  R_X1,  O_NONE, C_ALL);
            6'd46: r = mk(OP_MUL, R_DBM,  R_X1,  R_X1,  O_NONE, C_ALL);
            6'd47: r = mk(OP_MUL, R_X1,   R_DYB, R_X1,  O_NONE, C_ALL);
            6'd48: r = mk(OP_SUB, R_X0,   R_X1,  R_B,   O_NONE, C_ALL);
            6'd49: r = mk(OP_MUL, R_DY2,  R_A,   R_X0,  O_NONE, C_ALL);
            6'd50: r = mk(OP_MUL, R_DY2,  R_B,   R_X1,  O_NONE, C_ALL);
            6'd51: r = mk(OP_ADD, R_X0,   R_X1,  R_X0,  O_RHS,  C_ALL);
            6'd52: r = mk(OP_MUL, R_DFE,  R_DYF, R_X0,  O_NONE, C_ALL);
            6'd53: r = mk(OP_MUL, R_DBE,  R_DYB, R_X1,  O_NONE, C_ALL);
            6'd54: r = mk(OP_ADD, R_X0,   R_X1,  R_X0,  O_NONE, C_ALL);
            6'd55: r = mk(OP_MUL, R_DY2,  R_X0,  R_X0,  O_NONE, C_ALL);
            6'd56: r = mk(OP_NEG, R_X0,   R_X0,  R_X0,  O_DIAG, C_ALL);
            6'd57: r = mk(OP_MUL, R_DY2,  R_DBE, R_X0,  O_NONE, C_SUB);
            6'd58: r = mk(OP_MUL, R_X0,   R_DYB, R_X0,  O_SUB,  C_SUB);
            6'd59: r = mk(OP_MUL, R_DY2,  R_DFE, R_X0,  O_NONE, C_SUP);
            6'd60: r = mk(OP_MUL, R_X0,   R_DYF, R_X0,  O_SUP,  C_SUP);
            default: r = mk(OP_ADD, R_X0, R_X0,  R_X0,  O_NONE, C_ALL);
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/energy_stencil_row_assembly.sv -----
// Energy-equation tridiagonal row assembly, top level.
// Streams grid points of a wall-normal column (Q32.32) and emits one
// tridiagonal row (rhs, diag, sub, sup) per point from the third point of a
// column onward. The first two points of a column are stored in the window
// without stalling the input. A point that completes a row holds the input
// while the window and constants are loaded into the working register file
// and a 61-step microprogram runs on shared units: 34 multiplies on a
// four-pass 32x32 multiplier and 3 reciprocals at one quotient bit a cycle.
// The finished row sits in an output register, so the next point is taken
// while the row waits. Results saturate; m_tuser overflow marks any
// saturation or zero spacing within the row.
module energy_stencil_row_assembly (
    input  logic         clk,
    input  logic         rst_n,
    // velocity, lam_visc, turb_visc, turb_cond, wall_dist, temperature
    input  logic [383:0] s_tdata,
    // first_point
    input  logic [0:0]   s_tuser,
    input  logic         s_tlast,
    input  logic         s_tvalid,
    output logic         s_tready,
    // rhs, diag, sub, sup
    output logic [255:0] m_tdata,
    // has_sub, has_sup, overflow
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [62:0]  cfg_data
);
    import esra_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EX   = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [62:0] cp_reg;
    logic        ten_reg;
    logic [62:0] tm_reg;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  pc_reg, pc_next;
    logic [4:0]  ld_reg, ld_next;
    logic [1:0]  ps_reg, ps_next;
    logic        frp_reg, frp_next;
    logic        flag_reg, flag_next;
    logic        m_tvalid_reg, m_tvalid_next;

    point_t      win_reg [2];
    point_t      cur_reg;
    logic        last_reg;
    logic        hassub_reg;
    q_t          res_rhs_reg, res_diag_reg, res_sub_reg, res_sup_reg;
    logic [255:0] out_data_reg;
    logic [2:0]  out_user_reg;
    logic        out_last_reg;

    point_t      in_pt;
    logic        in_acc;
    logic [1:0]  ps_eff;
    logic        frp_eff;
    uop_t        uop;
    logic        cond_ok;
    logic        is_unit;
    logic        pc_end;
    logic        load_out;

    logic        rf_we;
    logic [4:0]  rf_waddr;
    q_t          rf_wdata;
    q_t          rd_a, rd_b;
    q_t          ld_val;

    logic [64:0] alu_x;
    logic        alu_sat;
    q_t          alu_val;

    logic        mul_start, rcp_start;
    unit_res_t   mul_res, rcp_res;
    unit_res_t   unit_res;
    logic        wr_res;
    logic        wr_sat;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg  <= '0;
            ten_reg <= 1'b0;
            tm_reg  <= 63'h0000_0001_0000_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CP_OVER_PR:  cp_reg  <= cfg_data;
                CFG_TURB_ENABLE: ten_reg <= cfg_data[0];
                CFG_TURB_MULT:   tm_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_pt    = point_t'(s_tdata);
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign ps_eff   = s_tuser[0] ? 2'd0 : ps_reg;
    assign frp_eff  = s_tuser[0] | frp_reg;

    assign uop     = prog_rom(pc_reg);
    assign cond_ok = (uop.cond == C_ALL) || ((uop.cond == C_SUB) && hassub_reg)
                     || ((uop.cond == C_SUP) && !last_reg);
    assign is_unit = (uop.op == OP_MUL) || (uop.op == OP_RCP);
    assign pc_end  = (pc_reg == 6'(PROG_LEN - 1));
    assign load_out = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // window and constants into the register file
    always_comb
    begin
        unique case (ld_reg)
            R_U0:   ld_val = win_reg[0].u;
            R_U1:   ld_val = win_reg[1].u;
            R_U2:   ld_val = cur_reg.u;
            R_MU0:  ld_val = win_reg[0].mu;
            R_MU1:  ld_val = win_reg[1].mu;
            R_MU2:  ld_val = cur_reg.mu;
            R_MT0:  ld_val = win_reg[0].mt;
            R_MT1:  ld_val = win_reg[1].mt;
            R_MT2:  ld_val = cur_reg.mt;
            R_LT0:  ld_val = win_reg[0].lt;
            R_LT1:  ld_val = win_reg[1].lt;
            R_LT2:  ld_val = cur_reg.lt;
            R_Y0:   ld_val = win_reg[0].y;
            R_Y1:   ld_val = win_reg[1].y;
            R_Y2:   ld_val = cur_reg.y;
            R_T0:   ld_val = win_reg[0].t;
            R_T1:   ld_val = win_reg[1].t;
            R_T2:   ld_val = cur_reg.t;
            R_C:    ld_val = q_t'({1'b0, cp_reg});
            R_F:    ld_val = ten_reg ? q_t'({1'b0, tm_reg}) : Q_ONE;
            R_HALF: ld_val = Q_HALF;
            default: ld_val = '0;
        endcase
    end

    // add / subtract / negate with saturation
    always_comb
    begin
        case (uop.op)
            OP_ADD:  alu_x = {rd_a[63], rd_a} + {rd_b[63], rd_b};
            OP_SUB:  alu_x = {rd_a[63], rd_a} - {rd_b[63], rd_b};
            default: alu_x = 65'd0 - {rd_a[63], rd_a};
        endcase
        alu_sat = alu_x[64] ^ alu_x[63];
        if (alu_sat)
        begin
            alu_val = alu_x[64] ? Q_MIN : Q_MAX;
        end
        else
        begin
            alu_val = q_t'(alu_x[63:0]);
        end
    end

    assign unit_res  = (uop.op == OP_MUL) ? mul_res : rcp_res;
    assign mul_start = (state_reg == S_EX) && (uop.op == OP_MUL);
    assign rcp_start = (state_reg == S_EX) && (uop.op == OP_RCP);

    always_comb
    begin
        wr_res = 1'b0;
        wr_sat = 1'b0;
        rf_we    = 1'b0;
        rf_waddr = uop.d;
        rf_wdata = unit_res.val;
        if (state_reg == S_LOAD)
        begin
            rf_we    = 1'b1;
            rf_waddr = ld_reg;
            rf_wdata = ld_val;
        end
        else if ((state_reg == S_EX) && !is_unit)
        begin
            wr_res   = 1'b1;
            wr_sat   = alu_sat;
            rf_we    = 1'b1;
            rf_wdata = alu_val;
        end
        else if ((state_reg == S_WAIT) && unit_res.done)
        begin
            wr_res = 1'b1;
            wr_sat = unit_res.sat;
            rf_we  = 1'b1;
        end
    end

    esra_regfile u_rf (
        .clk     (clk),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .raddr_a (uop.a),
        .raddr_b (uop.b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    esra_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (rd_a),
        .b     (rd_b),
        .res   (mul_res)
    );

    esra_recip u_rcp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rcp_start),
        .a     (rd_a),
        .res   (rcp_res)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        ld_next       = ld_reg;
        ps_next       = ps_reg;
        frp_next      = frp_reg;
        flag_next     = flag_reg | wr_sat;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (ps_eff < 2'd2)
                    begin
                        ps_next  = s_tlast ? 2'd0 : ps_eff + 2'd1;
                        frp_next = s_tlast | frp_eff;
                    end
                    else
                    begin
                        ps_next    = ps_eff;
                        frp_next   = frp_eff;
                        flag_next  = 1'b0;
                        ld_next    = '0;
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                ld_next = ld_reg + 5'd1;
                if (ld_reg == 5'(NUM_LOAD - 1))
                begin
                    pc_next    = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (cond_ok)
                begin
                    state_next = S_EX;
                end
                else if (pc_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pc_next = pc_reg + 6'd1;
                end
            end
            S_EX, S_WAIT:
            begin
                if ((state_reg == S_EX) && is_unit)
                begin
                    state_next = S_WAIT;
                end
                else if (wr_res)
                begin
                    if (pc_end)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pc_next    = pc_reg + 6'd1;
                        state_next = S_RD;
                    end
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    m_tvalid_next = 1'b1;
                    frp_next      = last_reg;
                    ps_next       = last_reg ? 2'd0 : 2'd2;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pc_reg       <= '0;
            ld_reg       <= '0;
            ps_reg       <= '0;
            frp_reg      <= 1'b1;
            flag_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            win_reg[0]   <= '0;
            win_reg[1]   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            ld_reg       <= ld_next;
            ps_reg       <= ps_next;
            frp_reg      <= frp_next;
            flag_reg     <= flag_next;
            m_tvalid_reg <= m_tvalid_next;
            if (in_acc && (ps_eff < 2'd2))
            begin
                win_reg[ps_eff[0]] <= in_pt;
            end
            else if (load_out)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= cur_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_acc && (ps_eff == 2'd2))
        begin
            cur_reg     <= in_pt;
            last_reg    <= s_tlast;
            hassub_reg  <= !frp_eff;
            res_sub_reg <= '0;
            res_sup_reg <= '0;
        end
        if (wr_res)
        begin
            case (uop.o)
                O_RHS:   res_rhs_reg  <= rf_wdata;
                O_DIAG:  res_diag_reg <= rf_wdata;
                O_SUB:   res_sub_reg  <= rf_wdata;
                O_SUP:   res_sup_reg  <= rf_wdata;
                default: ;
            endcase
        end
        if (load_out)
        begin
            out_data_reg <= {res_sup_reg, res_sub_reg, res_diag_reg, res_rhs_reg};
            out_user_reg <= {flag_reg, !last_reg, hassub_reg};
            out_last_reg <= last_reg;
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;
    assign m_tvalid = m_tvalid_reg;

    a_mul_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        mul_res.done |-> (state_reg == S_WAIT))
        else $error("multiplier finished outside a wait step");

    a_rcp_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        rcp_res.done |-> (state_reg == S_WAIT))
        else $error("reciprocal finished outside a wait step");

    a_no_sub_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[191:128] == 64'd0))
        else $error("sub nonzero on a first row");

    a_no_sup_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[255:192] == 64'd0 && m_tlast))
        else $error("sup nonzero or last_row clear on a row without sup");

    a_ps_range: assert property (@(posedge clk) disable iff (!rst_n)
        ps_reg != 2'd3)
        else $error("window count out of range");

endmodule

// ----- hw/rtl/esra_regfile.sv -----
// Working register file: one write port, two registered read ports.
module esra_regfile (
    input  logic          clk,
    input  logic          we,
    input  logic [4:0]    waddr,
    input  esra_pkg::q_t  wdata,
    input  logic [4:0]    raddr_a,
    input  logic [4:0]    raddr_b,
    output esra_pkg::q_t  rdata_a,
    output esra_pkg::q_t  rdata_b
);
    import esra_pkg::*;

    q_t mem [32];
    q_t rd_a_reg;
    q_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

// ----- hw/rtl/esra_mul.sv -----
// Q32.32 multiplier: four 32x32 partial products, then round and saturate.
module esra_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  esra_pkg::q_t       a,
    input  esra_pkg::q_t       b,
    output esra_pkg::unit_res_t res
);
    import esra_pkg::*;

    logic         busy_reg, busy_next;
    logic         fin_reg, fin_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic [63:0]  x_reg, x_next;
    logic [63:0]  y_reg, y_next;
    logic         neg_reg, neg_next;
    logic [127:0] acc_reg, acc_next;

    logic [31:0]  xs;
    logic [31:0]  ys;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [64:0]  s1;
    logic [63:0]  lim;
    logic         sat;

    always_comb
    begin
        xs = cnt_reg[1] ? x_reg[63:32] : x_reg[31:0];
        ys = cnt_reg[0] ? y_reg[63:32] : y_reg[31:0];
        pp = xs * ys;
        case (cnt_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
            x_next    = a[63] ? 64'(~a + 64'd1) : 64'(a);
            y_next    = b[63] ? 64'(~b + 64'd1) : 64'(b);
            neg_next  = a[63] ^ b[63];
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + pp_sh;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
    end

    // Round half away from zero on the magnitude, then range check.
    always_comb
    begin
        s1  = {1'b0, acc_reg[95:32]} + {64'd0, acc_reg[31]};
        lim = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        sat = (|acc_reg[127:96]) | s1[64] | (s1[63:0] > lim);
        res.done = fin_reg;
        res.sat  = sat;
        if (sat)
        begin
            res.val = neg_reg ? Q_MIN : Q_MAX;
        end
        else
        begin
            res.val = neg_reg ? q_t'(~s1[63:0] + 64'd1) : q_t'(s1[63:0]);
        end
    end

endmodule

// ----- hw/rtl/esra_recip.sv -----
// Q32.32 reciprocal: 2^64 / |a| by restoring division, one bit per cycle.
module esra_recip (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  esra_pkg::q_t       a,
    output esra_pkg::unit_res_t res
);
    import esra_pkg::*;

    logic        busy_reg, busy_next;
    logic        fin_reg, fin_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] m_reg, m_next;
    logic        neg_reg, neg_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;

    logic [64:0] rem_sh;
    logic        ge;
    logic [64:0] rem_sub;
    logic        rnd;
    logic [63:0] q1;
    logic        m_zero;
    logic        m_one;

    always_comb
    begin
        // dividend is a single one above 64 zeros
        rem_sh  = {rem_reg, (cnt_reg == 7'd0)};
        ge      = rem_sh >= {1'b0, m_reg};
        rem_sub = rem_sh - {1'b0, m_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        cnt_next  = cnt_reg;
        m_next    = m_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            m_next    = a[63] ? 64'(~a + 64'd1) : 64'(a);
            neg_next  = a[63];
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[63:0] : rem_sh[63:0];
            q_next   = {q_reg[62:0], ge};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd64)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    always_comb
    begin
        m_zero = (m_reg == 64'd0);
        m_one  = (m_reg == 64'd1);
        rnd    = {rem_reg, 1'b0} >= {1'b0, m_reg};
        q1     = q_reg + {63'd0, rnd};
        res.done = fin_reg;
        res.sat  = m_zero | m_one | (!neg_reg && q1[63]);
        if (m_zero)
        begin
            res.val = Q_MAX;
        end
        else if (m_one || (!neg_reg && q1[63]))
        begin
            res.val = neg_reg ? Q_MIN : Q_MAX;
        end
        else
        begin
            res.val = neg_reg ? q_t'(~q1 + 64'd1) : q_t'(q1);
        end
    end

endmodule
